FILE: rtl/core/ccsb_pkg.sv
// Shared types and constants for the character-class span/break matcher.
package ccsb_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned OUT_POS_W   = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHORED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd6;

  typedef enum logic [1:0] {
    MODE_SPAN   = 2'd0,
    MODE_BREAK  = 2'd1,
    MODE_ANY    = 2'd2,
    MODE_NOTANY = 2'd3
  } match_mode_t;

  typedef enum logic [2:0] {
    PH_SEEK = 3'b001,
    PH_RUN  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic last;
    logic member;
  } cls_item_t;

  // Settings the back end needs.
  typedef struct packed {
    match_mode_t             mode;
    logic                    anchored;
    logic [OUT_POS_W-1:0]    base;
  } match_cfg_t;

endpackage

FILE: rtl/core/ccsb_front.sv
// Front end: configuration registers and per-byte class lookup.
module ccsb_front import ccsb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output cls_item_t             q_item,
  output match_cfg_t            match_cfg
);

  logic [255:0]           class_r;
  match_mode_t            mode_r;
  logic                   anchored_r;
  logic [OUT_POS_W-1:0]   base_r;
  logic                   cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r    <= '0;
      mode_r     <= MODE_SPAN;
      anchored_r <= 1'b0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_0:  class_r[63:0]    <= cfg_data;
        REG_CLASS_1:  class_r[127:64]  <= cfg_data;
        REG_CLASS_2:  class_r[191:128] <= cfg_data;
        REG_CLASS_3:  class_r[255:192] <= cfg_data;
        REG_MODE:     mode_r           <= match_mode_t'(cfg_data[1:0]);
        REG_ANCHORED: anchored_r       <= cfg_data[0];
        REG_BASE:     base_r           <= cfg_data[OUT_POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready     = ~q_full;
  assign q_push        = in_tvalid & in_tready;
  assign q_item.last   = in_tlast;
  assign q_item.member = class_r[in_tdata];

  assign match_cfg.mode     = mode_r;
  assign match_cfg.anchored = anchored_r;
  assign match_cfg.base     = base_r;

endmodule

FILE: rtl/core/ccsb_queue.sv
// Short queue of classified items between front and back.
module ccsb_queue import ccsb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  input  logic      pop,
  output cls_item_t head_item,
  output logic      empty,
  output logic      full
);

  cls_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign empty     = (count_r == '0);
  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

FILE: rtl/core/ccsb_back.sv
// Back end: match phase sequencer and result register.
module ccsb_back import ccsb_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  match_cfg_t            match_cfg,
  input  cls_item_t             head_item,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2*OUT_POS_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned EW = (PW > OUT_POS_W) ? PW : OUT_POS_W;

  phase_t                 phase_r, phase_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [PW-1:0]          run_r, run_nxt;
  logic                   out_valid_r;
  logic                   found_r;
  logic [OUT_POS_W-1:0]   start_r, end_r;

  logic [EW-1:0]          base_ext;
  logic [PW-1:0]          base_pw;
  logic [PW-1:0]          pos_inc;
  logic [EW-1:0]          abs_zero, abs_pos, abs_pos1, abs_run;
  logic                   emit, e_found;
  logic [OUT_POS_W-1:0]   e_start, e_end;
  logic                   hit;

  assign base_ext = EW'(match_cfg.base);
  assign base_pw  = base_ext[PW-1:0];
  assign pos_inc  = pos_r + 1'b1;
  // Absolute positions wrap at PW bits, then keep their low 32 bits.
  assign abs_zero = EW'(base_pw);
  assign abs_pos  = EW'(PW'(base_pw + pos_r));
  assign abs_pos1 = EW'(PW'(base_pw + pos_inc));
  assign abs_run  = EW'(PW'(base_pw + run_r));

  assign q_pop = ~q_empty & (~out_valid_r | out_tready);
  assign hit   = (match_cfg.mode == MODE_NOTANY) ? ~head_item.member : head_item.member;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    run_nxt   = run_r;
    emit      = 1'b0;
    e_found   = 1'b0;
    e_start   = '0;
    e_end     = '0;
    if (q_pop) begin
      unique case (phase_r)
        PH_SEEK: begin
          if (head_item.last) begin
            emit = 1'b1;
            if (match_cfg.mode == MODE_BREAK) begin
              e_found = 1'b1;
              e_start = abs_zero[OUT_POS_W-1:0];
              e_end   = abs_pos[OUT_POS_W-1:0];
            end
            phase_nxt = PH_SEEK;
            pos_nxt   = '0;
            run_nxt   = '0;
          end else if (match_cfg.mode == MODE_BREAK) begin
            if (head_item.member) begin
              emit      = 1'b1;
              e_found   = 1'b1;
              e_start   = abs_zero[OUT_POS_W-1:0];
              e_end     = abs_pos[OUT_POS_W-1:0];
              phase_nxt = PH_DONE;
            end else begin
              pos_nxt = pos_inc;
            end
          end else if (hit) begin
            if (match_cfg.mode == MODE_SPAN) begin
              run_nxt   = pos_r;
              pos_nxt   = pos_inc;
              phase_nxt = PH_RUN;
            end else begin
              emit      = 1'b1;
              e_found   = 1'b1;
              e_start   = abs_pos[OUT_POS_W-1:0];
              e_end     = abs_pos1[OUT_POS_W-1:0];
              phase_nxt = PH_DONE;
            end
          end else if (match_cfg.anchored) begin
            emit      = 1'b1;
            phase_nxt = PH_DONE;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_RUN: begin
          if (head_item.last) begin
            emit      = 1'b1;
            e_found   = 1'b1;
            e_start   = abs_run[OUT_POS_W-1:0];
            e_end     = abs_pos[OUT_POS_W-1:0];
            phase_nxt = PH_SEEK;
            pos_nxt   = '0;
            run_nxt   = '0;
          end else if (head_item.member) begin
            pos_nxt = pos_inc;
          end else begin
            emit      = 1'b1;
            e_found   = 1'b1;
            e_start   = abs_run[OUT_POS_W-1:0];
            e_end     = abs_pos[OUT_POS_W-1:0];
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          // Decided: drop bytes, the end marker opens a new subject.
          if (head_item.last) begin
            phase_nxt = PH_SEEK;
            pos_nxt   = '0;
            run_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEEK;
      pos_r       <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      run_r   <= run_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found_r <= e_found;
      start_r <= e_start;
      end_r   <= e_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {end_r, start_r};
  assign out_tuser  = found_r;

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && phase_r == PH_DONE) |-> !emit)
    else $error("result after decision");
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_item.last) |=> (phase_r == PH_SEEK && pos_r == '0))
    else $error("end marker did not restart search");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (start_r == '0 && end_r == '0))
    else $error("miss carries nonzero positions");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("pending result overwritten");

endmodule

FILE: rtl/core/char_class_span_break_matcher.sv
// Top level of the character-class span/break/any/notany matcher.
// An accepted item is written to the queue; popping it from the queue head loads the result.
// Throughput: one item per cycle; a 4-entry queue decouples the two sides, and
// in_tready falls only once the queue fills behind a result held by out_tready.
// Reset (rst_n low, synchronous) clears config registers, queue and search phase.
// No clearing pass; the block takes items the cycle after reset releases.
module char_class_span_break_matcher import ccsb_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // subject byte stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [7:0] data_byte
  input  logic                    in_tlast,   // end_marker
  // match results
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [2*OUT_POS_W-1:0]  out_tdata,  // [31:0] start_pos, [63:32] end_pos
  output logic                    out_tuser   // [0] found
);

  logic       q_push, q_pop, q_empty, q_full;
  cls_item_t  q_in_item, q_head_item;
  match_cfg_t match_cfg;

  // Front: registers plus the 256-entry class bit lookup, done on accept.
  ccsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item),
    .match_cfg (match_cfg)
  );

  // Queue carries only the class bit and the end marker per item.
  ccsb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: search phase, position counters, result register.
  ccsb_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .match_cfg  (match_cfg),
    .head_item  (q_head_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: bench/tb_char_class_span_break_matcher.sv
// Self-checking testbench for the char-class span/break/any/notany matcher.
module tb_char_class_span_break_matcher import ccsb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to wait after the last expected result before touching config.
  // The top level buffers items in a 4-entry queue ahead of the result register, so items
  // that make no result may still be draining from it.
  localparam int SETTLE_CYCLES = 8;

  // One decided match as it leaves the block.
  typedef struct {
    logic        found;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
  } match_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // [7:0] data_byte
  logic                   in_tlast;   // end_marker
  logic                   out_tvalid;
  logic                   out_tready;
  logic [2*OUT_POS_W-1:0] out_tdata;  // [31:0] start_pos, [63:32] end_pos
  logic                   out_tuser;  // [0] found

  char_class_span_break_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: own copy of config and search state
  // ---------------------------------------------------------------------
  logic [255:0] class_map;
  match_mode_t  cur_mode;
  logic         cur_anchored;
  logic [31:0]  cur_base;

  phase_t       sub_phase;
  logic [31:0]  sub_index;   // index of the next subject byte
  logic [31:0]  run_from;    // index where the open span run began

  match_t       pending_matches[$];

  // Bookkeeping
  int n_items;
  int n_results;
  int n_subjects;
  int n_cfg;
  int n_errors;

  // When set, both sides run without gaps.
  bit steady;
  int stall_left;

  match_t got_m;
  match_t want_m;

  function automatic int draw_gap();
    if (steady) return 0;
    case ($urandom_range(0, 3))
      0, 1:    return 0;
      2:       return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic void queue_match(logic hit, logic [31:0] s_idx, logic [31:0] e_idx);
    match_t m;
    m.found     = hit;
    m.start_pos = hit ? cur_base + s_idx : 32'd0;
    m.end_pos   = hit ? cur_base + e_idx : 32'd0;
    pending_matches.push_back(m);
  endfunction

  function automatic void restart_subject();
    sub_phase = PH_SEEK;
    sub_index = '0;
    run_from  = '0;
  endfunction

  // Advance the search by one accepted item; queue whatever it decides.
  function automatic void predict_match(logic [7:0] b, logic last);
    logic member;
    member = class_map[b];

    // decided: swallow bytes, the next end marker opens a fresh subject
    if (sub_phase != PH_SEEK && sub_phase != PH_RUN) begin
      if (last) restart_subject();
      return;
    end

    if (last) begin
      if (sub_phase == PH_RUN)
        queue_match(1'b1, run_from, sub_index);
      else if (cur_mode == MODE_BREAK)
        queue_match(1'b1, 32'd0, sub_index);
      else
        queue_match(1'b0, 32'd0, 32'd0);
      restart_subject();
      return;
    end

    // open run keeps testing the plain bitmap whatever the mode is now
    if (sub_phase == PH_RUN) begin
      if (member) begin
        sub_index = sub_index + 1;
      end else begin
        queue_match(1'b1, run_from, sub_index);
        sub_phase = PH_DONE;
      end
      return;
    end

    if (cur_mode == MODE_BREAK) begin
      if (member) begin
        queue_match(1'b1, 32'd0, sub_index);
        sub_phase = PH_DONE;
      end else begin
        sub_index = sub_index + 1;
      end
      return;
    end

    if (cur_mode == MODE_NOTANY) member = ~member;

    if (member) begin
      if (cur_mode == MODE_SPAN) begin
        run_from  = sub_index;
        sub_phase = PH_RUN;
        sub_index = sub_index + 1;
      end else begin
        queue_match(1'b1, sub_index, sub_index + 1);
        sub_phase = PH_DONE;
      end
    end else if (cur_anchored) begin
      queue_match(1'b0, 32'd0, 32'd0);
      sub_phase = PH_DONE;
    end else begin
      sub_index = sub_index + 1;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, check each accepted result in order
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      stall_left = draw_gap();
      got_m.found     = out_tuser;
      got_m.start_pos = out_tdata[31:0];
      got_m.end_pos   = out_tdata[63:32];
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, got_m.found}, 32'd0);
      end else begin
        want_m = pending_matches.pop_front();
        if (got_m.found !== want_m.found)
          report_mismatch("found", {31'd0, got_m.found}, {31'd0, want_m.found});
        if (got_m.start_pos !== want_m.start_pos)
          report_mismatch("start_pos", got_m.start_pos, want_m.start_pos);
        if (got_m.end_pos !== want_m.end_pos)
          report_mismatch("end_pos", got_m.end_pos, want_m.end_pos);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Send one item: byte and end flag, after a random gap.
  task automatic push_byte(logic [7:0] b, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (last) n_subjects++;
    predict_match(b, last);
  endtask

  // End marker with junk in the byte lane (ignored by the block).
  task automatic push_end();
    push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic stop_input();
    @(negedge clk) in_tvalid <= 1'b0;
  endtask

  // Hold the sender until every expected result is back, then let the
  // queue drain items that produce nothing.
  task automatic wait_drained();
    stop_input();
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Config write; caller makes sure the block is idle.
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
    case (idx)
      REG_CLASS_0:  class_map[63:0]    = value;
      REG_CLASS_1:  class_map[127:64]  = value;
      REG_CLASS_2:  class_map[191:128] = value;
      REG_CLASS_3:  class_map[255:192] = value;
      REG_MODE:     cur_mode           = match_mode_t'(value[1:0]);
      REG_ANCHORED: cur_anchored       = value[0];
      REG_BASE:     cur_base           = value[31:0];
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic load_class(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2, logic [63:0] w3);
    set_reg(REG_CLASS_0, w0);
    set_reg(REG_CLASS_1, w1);
    set_reg(REG_CLASS_2, w2);
    set_reg(REG_CLASS_3, w3);
  endtask

  task automatic set_mode(match_mode_t m, logic anch);
    set_reg(REG_MODE, {62'd0, m});
    set_reg(REG_ANCHORED, {63'd0, anch});
  endtask

  // Pick a byte that is (or is not) in the class; falls back to any byte.
  function automatic logic [7:0] pick_byte(logic want_member);
    logic [7:0] b;
    b = '0;
    for (int t = 0; t < 16; t++) begin
      b = 8'($urandom_range(0, 255));
      if (class_map[b] == want_member) return b;
    end
    return b;
  endfunction

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 4))
      0:       return 64'd0;
      1:       return '1;
      2:       return {$urandom, $urandom};
      3:       return 64'd1 << $urandom_range(0, 63) | 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Digits 0x30..0x39 live in word 0 bits 48..57.
  localparam logic [63:0] DIGITS = 64'h03FF_0000_0000_0000;
  localparam logic [63:0] COMMA  = 64'h0000_1000_0000_0000;  // 0x2C

  // Out of reset: empty class, span mode, empty subject finds nothing.
  task automatic test_reset_defaults();
    push_end();
  endtask

  task automatic test_span_runs();
    wait_drained();
    load_class(DIGITS, 64'd0, 64'd0, 64'd0);
    set_mode(MODE_SPAN, 1'b0);
    // run decided by a non-digit; the trailing byte and end marker are swallowed
    push_text("a12b");
    push_byte("z", 1'b0);
    push_end();
    // run still open at the end marker
    push_text("x9");
    push_end();
  endtask

  task automatic test_break_delimiters();
    wait_drained();
    load_class(COMMA, 64'd0, 64'd0, 64'd0);
    set_mode(MODE_BREAK, 1'b0);
    push_text("ab,");
    push_end();
    // empty subject: empty match at the base
    push_end();
  endtask

  // ANY and NOTANY against the extreme byte values 0x00 and 0xFF.
  task automatic test_single_byte_modes();
    wait_drained();
    load_class(64'd1, 64'd0, 64'd0, 64'h8000_0000_0000_0000);
    set_mode(MODE_ANY, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_end();
    wait_drained();
    set_mode(MODE_NOTANY, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_end();
  endtask

  task automatic test_anchored();
    wait_drained();
    load_class(DIGITS, 64'd0, 64'd0, 64'd0);
    set_mode(MODE_SPAN, 1'b1);
    push_byte("a", 1'b0);   // first byte fails: decided at once
    push_end();
    push_text("5x");
    push_end();
  endtask

  // Base at the top of the range: end position wraps to zero.
  task automatic test_position_wrap();
    wait_drained();
    set_mode(MODE_SPAN, 1'b0);
    set_reg(REG_BASE, 64'hFFFF_FFFF);
    push_byte("7", 1'b0);
    push_end();
    wait_drained();
    set_reg(REG_BASE, 64'd0);
  endtask

  // Run opened in span mode keeps going after the mode flips to break.
  task automatic test_mode_change_in_run();
    wait_drained();
    push_byte("3", 1'b0);
    wait_drained();
    set_mode(MODE_BREAK, 1'b0);
    push_byte("4", 1'b0);
    push_byte("q", 1'b0);
    push_end();
  endtask

  // ---------------------------------------------------------------------
  // Random phases: fresh config each phase, mostly well-formed subjects
  // ---------------------------------------------------------------------
  task automatic test_random_phases(int n_phases, int items_per_phase);
    int start_items;
    int len;
    int member_pct;
    logic [63:0] base_val;
    for (int p = 0; p < n_phases; p++) begin
      wait_drained();
      // first two phases pin the class to empty and full
      if (p == 0)      load_class('0, '0, '0, '0);
      else if (p == 1) load_class('1, '1, '1, '1);
      else             load_class(random_word(), random_word(), random_word(), random_word());
      set_mode(match_mode_t'(p % 4), 1'((p / 4) % 2));
      case ($urandom_range(0, 3))
        0:       base_val = 64'd0;
        1:       base_val = 64'hFFFF_FFFF;
        2:       base_val = 64'hFFFF_FFF0 + $urandom_range(0, 15);
        default: base_val = {32'd0, $urandom};
      endcase
      set_reg(REG_BASE, base_val);
      member_pct = $urandom_range(10, 90);
      start_items = n_items;
      while (n_items - start_items < items_per_phase) begin
        steady = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 4) != 0) begin
          len = $urandom_range(0, 10);
          for (int i = 0; i < len; i++)
            push_byte(pick_byte($urandom_range(0, 99) < member_pct), 1'b0);
          push_end();
        end else begin
          // noise: loose bytes with stray end markers
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
        // now and then hold the sender until all results are back
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
      steady = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    stall_left = 0;
    steady     = 1'b0;
    n_items    = 0;
    n_results  = 0;
    n_subjects = 0;
    n_cfg      = 0;
    n_errors   = 0;
    class_map    = '0;
    cur_mode     = MODE_SPAN;
    cur_anchored = 1'b0;
    cur_base     = '0;
    restart_subject();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_span_runs();
    test_break_delimiters();
    test_single_byte_modes();
    test_anchored();
    test_position_wrap();
    test_mode_change_in_run();
    test_random_phases(16, 68);

    // drain: all results back, then a settle wait for anything stray
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d subjects), checked %0d results, %0d register writes.",
             n_items, n_subjects, n_results, n_cfg);
    $display("All four modes, anchored and free, empty/full/random classes, wrapping bases.");
    if (n_errors == 0 && pending_matches.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~1200 items with full gaps
  // and stalls is well under half a millisecond).
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still expected", pending_matches.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: char_class_span_break_matcher.f
rtl/core/ccsb_pkg.sv
rtl/core/ccsb_front.sv
rtl/core/ccsb_queue.sv
rtl/core/ccsb_back.sv
rtl/core/char_class_span_break_matcher.sv
bench/tb_char_class_span_break_matcher.sv
